/* sv/pstt_pkg.sv */
`timescale 1ns / 1ps
package pstt_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned FillW = SlotW + 1;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [15:0] HeaderBytes = 16'd54;
  localparam logic [15:0] WebPortAReset = 16'd80;
  localparam logic [15:0] WebPortBReset = 16'd443;
  localparam logic [15:0] DnsPortReset = 16'd53;

  typedef enum logic [1:0] {
    CfgWebPortA = 2'd0,
    CfgWebPortB = 2'd1,
    CfgDnsPort  = 2'd2,
    CfgNone     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StUpdate,
    StLead,
    StDone,
    StOut
  } state_e;

  // controller to table commands
  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic lead;
  } tbl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic lead_done;
  } tbl_sts_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

/* sv/pstt_ram.sv */
`timescale 1ns / 1ps
module pstt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/pstt_table.sv */
`timescale 1ns / 1ps
// one address table: search, add or insert, then leader rescan
module pstt_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pstt_pkg::tbl_cmd_t cmd_i,
  input  logic              en_i,
  input  logic [31:0]       key_i,
  input  logic [31:0]       amount_i,
  output pstt_pkg::tbl_sts_t sts_o,
  output logic              dropped_o,
  output logic              valid_o,
  output logic [31:0]       lead_key_o,
  output logic [31:0]       lead_val_o
);
  import pstt_pkg::*;

  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] ptr_q, ptr_d;
  logic             rd_pend_q, rd_pend_d;
  logic [SlotW-1:0] prev_q, prev_d;
  logic             hit_q, hit_d;
  logic [SlotW-1:0] hit_slot_q, hit_slot_d;
  logic             en_q, en_d;
  logic [31:0]      key_q, amt_q;
  logic [31:0]      best_q, best_d;
  logic [SlotW-1:0] lead_q, lead_d;
  logic             dropped_q, dropped_d;

  logic             kwe, vwe;
  logic [SlotW-1:0] waddr, raddr;
  logic [31:0]      vwdata, krdata, vrdata;

  pstt_ram #(.Width(32), .Depth(TableEntries)) u_keys (
    .clk_i, .we_i(kwe), .waddr_i(waddr), .wdata_i(key_q),
    .raddr_i(raddr), .rdata_o(krdata)
  );
  pstt_ram #(.Width(32), .Depth(TableEntries)) u_vals (
    .clk_i, .we_i(vwe), .waddr_i(waddr), .wdata_i(vwdata),
    .raddr_i(raddr), .rdata_o(vrdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
      amt_q <= amount_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ptr_q      <= '0;
      rd_pend_q  <= 1'b0;
      prev_q     <= '0;
      hit_q      <= 1'b0;
      hit_slot_q <= '0;
      en_q       <= 1'b0;
      best_q     <= '0;
      lead_q     <= '0;
      dropped_q  <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      ptr_q      <= ptr_d;
      rd_pend_q  <= rd_pend_d;
      prev_q     <= prev_d;
      hit_q      <= hit_d;
      hit_slot_q <= hit_slot_d;
      en_q       <= en_d;
      best_q     <= best_d;
      lead_q     <= lead_d;
      dropped_q  <= dropped_d;
    end
  end

  always_comb begin
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    rd_pend_d  = 1'b0;
    prev_d     = prev_q;
    hit_d      = hit_q;
    hit_slot_d = hit_slot_q;
    en_d       = en_q;
    best_d     = best_q;
    lead_d     = lead_q;
    dropped_d  = dropped_q;
    kwe        = 1'b0;
    vwe        = 1'b0;
    waddr      = hit_slot_q;
    vwdata     = amt_q;
    raddr      = ptr_q[SlotW-1:0];
    sts_o      = '0;

    if (cmd_i.start) begin
      en_d      = en_i;
      ptr_d     = '0;
      hit_d     = 1'b0;
      dropped_d = 1'b0;
    end

    if (cmd_i.scan) begin
      // compare the entry read last cycle while the next read goes out
      if (rd_pend_q && krdata == key_q && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = prev_q;
      end
      if (!en_q || hit_d || (ptr_q >= fill_q && !rd_pend_q)) begin
        sts_o.scan_done = 1'b1;
      end else if (ptr_q < fill_q) begin
        rd_pend_d = 1'b1;
        prev_d    = ptr_q[SlotW-1:0];
        ptr_d     = ptr_q + 1'b1;
      end
    end

    if (cmd_i.update) begin
      // an untouched table keeps its leader
      if (en_q) begin
        ptr_d  = '0;
        best_d = '0;
        lead_d = '0;
        if (hit_q) begin
          // the search parked the read on the hit slot, so vrdata holds its value
          vwe    = 1'b1;
          vwdata = sat_add(vrdata, amt_q);
        end else if (fill_q < FillW'(TableEntries)) begin
          kwe    = 1'b1;
          vwe    = 1'b1;
          waddr  = fill_q[SlotW-1:0];
          fill_d = fill_q + 1'b1;
        end else begin
          dropped_d = 1'b1;
        end
      end
    end

    if (cmd_i.lead) begin
      if (rd_pend_q && vrdata > best_q) begin
        best_d = vrdata;
        lead_d = prev_q;
      end
      if (!en_q || (ptr_q >= fill_q && !rd_pend_q)) begin
        sts_o.lead_done = 1'b1;
      end else if (ptr_q < fill_q) begin
        rd_pend_d = 1'b1;
        prev_d    = ptr_q[SlotW-1:0];
        ptr_d     = ptr_q + 1'b1;
      end
    end

    // hold read address on the hit slot so the update sees its value
    if (cmd_i.scan && hit_d) begin
      raddr = hit_slot_d;
    end
    if (cmd_i.scan && sts_o.scan_done && !hit_d) begin
      raddr = lead_q;
    end
    // after the leader pass, park the read on the leader slot
    if (!cmd_i.scan && !cmd_i.lead) begin
      raddr = lead_q;
    end
    if (cmd_i.lead && sts_o.lead_done) begin
      raddr = lead_d;
    end
  end

  assign dropped_o  = dropped_q;
  assign valid_o    = (fill_q != '0);
  assign lead_key_o = valid_o ? krdata : '0;
  assign lead_val_o = valid_o ? vrdata : '0;
endmodule

/* sv/pstt_ctrl.sv */
`timescale 1ns / 1ps
module pstt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pstt_pkg::tbl_cmd_t cmd_o,
  input  pstt_pkg::tbl_sts_t syn_sts_i,
  input  pstt_pkg::tbl_sts_t web_sts_i
);
  import pstt_pkg::*;

  state_e state_q, state_d;
  logic   syn_ok_q, syn_ok_d, web_ok_q, web_ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      syn_ok_q <= 1'b0;
      web_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      syn_ok_q <= syn_ok_d;
      web_ok_q <= web_ok_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    syn_ok_d    = syn_ok_q;
    web_ok_d    = web_ok_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          syn_ok_d    = 1'b0;
          web_ok_d    = 1'b0;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        // each table holds once its own search ends
        if (syn_sts_i.scan_done) syn_ok_d = 1'b1;
        if (web_sts_i.scan_done) web_ok_d = 1'b1;
        if (syn_ok_d && web_ok_d) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        syn_ok_d     = 1'b0;
        web_ok_d     = 1'b0;
        state_d      = StLead;
      end
      StLead: begin
        cmd_o.lead = 1'b1;
        if (syn_sts_i.lead_done) syn_ok_d = 1'b1;
        if (web_sts_i.lead_done) web_ok_d = 1'b1;
        if (syn_ok_d && web_ok_d) begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

/* sv/packet_stats_top_talker.sv */
`timescale 1ns / 1ps
// Per-packet traffic statistics with a SYN-per-source and a web-bytes-per-
// destination table of 256 entries each. Every accepted request yields one
// result. Each table is searched linearly one entry a cycle through its
// key/value RAM read port, then rescanned to find the leader. No clearing pass
// is needed after reset.
module packet_stats_top_talker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] ether_kind_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [15:0] frame_length_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] ipv4_total_o,
  output logic [31:0] tcp_total_o,
  output logic [31:0] udp_total_o,
  output logic [31:0] icmp_total_o,
  output logic [31:0] dns_total_o,
  output logic [31:0] top_syn_source_o,
  output logic [31:0] top_syn_count_o,
  output logic [31:0] top_web_dest_o,
  output logic [31:0] top_web_bytes_o,
  output logic        syn_leader_valid_o,
  output logic        web_leader_valid_o,
  output logic        table_dropped_o
);
  import pstt_pkg::*;

  logic [15:0] web_a_q, web_b_q, dns_q;
  logic [31:0] ipv4_q, tcp_q, udp_q, icmp_q, dns_cnt_q;
  tbl_cmd_t    cmd;
  tbl_sts_t    syn_sts, web_sts;
  logic        syn_drop, web_drop;
  logic        is_ip, is_tcp, is_udp, web_hit, syn_en, web_en;
  logic [31:0] payload;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      web_a_q <= WebPortAReset;
      web_b_q <= WebPortBReset;
      dns_q   <= DnsPortReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWebPortA: web_a_q <= cfg_data_i;
        CfgWebPortB: web_b_q <= cfg_data_i;
        CfgDnsPort:  dns_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_ip   = ether_kind_i == EtherIpv4;
  assign is_tcp  = is_ip && ip_protocol_i == ProtoTcp;
  assign is_udp  = is_ip && ip_protocol_i == ProtoUdp;
  assign web_hit = source_port_i == web_a_q || source_port_i == web_b_q ||
                   dest_port_i == web_a_q || dest_port_i == web_b_q;
  assign web_en  = is_tcp && web_hit;
  assign syn_en  = is_tcp && tcp_flag_bits_i[1];
  assign payload = (frame_length_i > HeaderBytes) ?
                   {16'd0, frame_length_i - HeaderBytes} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_q    <= '0;
      tcp_q     <= '0;
      udp_q     <= '0;
      icmp_q    <= '0;
      dns_cnt_q <= '0;
    end else if (cmd.start && is_ip) begin
      ipv4_q <= sat_add(ipv4_q, 32'd1);
      if (is_tcp) tcp_q <= sat_add(tcp_q, 32'd1);
      if (is_udp) begin
        udp_q <= sat_add(udp_q, 32'd1);
        if (source_port_i == dns_q || dest_port_i == dns_q) begin
          dns_cnt_q <= sat_add(dns_cnt_q, 32'd1);
        end
      end
      if (ip_protocol_i == ProtoIcmp) icmp_q <= sat_add(icmp_q, 32'd1);
    end
  end

  pstt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .syn_sts_i(syn_sts), .web_sts_i(web_sts)
  );

  pstt_table u_syn (
    .clk_i, .rst_ni, .cmd_i(cmd), .en_i(syn_en), .key_i(source_addr_i),
    .amount_i(32'd1), .sts_o(syn_sts), .dropped_o(syn_drop),
    .valid_o(syn_leader_valid_o), .lead_key_o(top_syn_source_o),
    .lead_val_o(top_syn_count_o)
  );

  pstt_table u_web (
    .clk_i, .rst_ni, .cmd_i(cmd), .en_i(web_en), .key_i(dest_addr_i),
    .amount_i(payload), .sts_o(web_sts), .dropped_o(web_drop),
    .valid_o(web_leader_valid_o), .lead_key_o(top_web_dest_o),
    .lead_val_o(top_web_bytes_o)
  );

  assign ipv4_total_o    = ipv4_q;
  assign tcp_total_o     = tcp_q;
  assign udp_total_o     = udp_q;
  assign icmp_total_o    = icmp_q;
  assign dns_total_o     = dns_cnt_q;
  assign table_dropped_o = syn_drop | web_drop;
endmodule

/* dv/pstt_checker.sv */
`timescale 1ns / 1ps
module pstt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] ether_kind_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [15:0] frame_length_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] ipv4_total_i,
  input  logic [31:0] tcp_total_i,
  input  logic [31:0] udp_total_i,
  input  logic [31:0] icmp_total_i,
  input  logic [31:0] dns_total_i,
  input  logic [31:0] top_syn_source_i,
  input  logic [31:0] top_syn_count_i,
  input  logic [31:0] top_web_dest_i,
  input  logic [31:0] top_web_bytes_i,
  input  logic        syn_leader_valid_i,
  input  logic        web_leader_valid_i,
  input  logic        table_dropped_i,
  output int          errors_o,
  output int          pending_o
);
  import pstt_pkg::*;

  typedef enum int {SynTbl = 0, WebTbl = 1} tbl_e;

  typedef struct packed {
    logic [31:0] ipv4, tcp, udp, icmp, dns;
    logic [31:0] syn_src, syn_cnt, web_dst, web_bytes;
    logic        syn_vld, web_vld, dropped;
  } stats_t;

  stats_t stats_q[$];

  logic [15:0] port_a, port_b, port_dns;
  logic [31:0] n_ipv4, n_tcp, n_udp, n_icmp, n_dns;
  logic [31:0] addr_key[2][TableEntries];
  logic [31:0] addr_val[2][TableEntries];
  int          fill[2];
  int          leader[2];

  assign pending_o = stats_q.size();

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic bump_addr(input tbl_e t, input logic [31:0] key, input logic [31:0] amount,
                           inout bit dropped);
    bit          hit;
    logic [31:0] best;
    int          idx;
    hit = 0;
    for (int i = 0; i < fill[t]; i++) begin
      if (!hit && addr_key[t][i] == key) begin
        addr_val[t][i] = sat_sum(addr_val[t][i], amount);
        hit = 1;
      end
    end
    if (!hit) begin
      if (fill[t] < TableEntries) begin
        addr_key[t][fill[t]] = key;
        addr_val[t][fill[t]] = amount;
        fill[t]++;
      end else begin
        dropped = 1;
      end
    end
    // strict compare keeps ties on the lowest slot
    best = 0;
    idx = 0;
    for (int i = 0; i < fill[t]; i++) begin
      if (addr_val[t][i] > best) begin
        best = addr_val[t][i];
        idx = i;
      end
    end
    leader[t] = idx;
  endtask

  task automatic predict_packet();
    stats_t      s;
    bit          drop;
    logic [15:0] payload;
    drop = 0;
    if (ether_kind_i == EtherIpv4) begin
      n_ipv4 = sat_sum(n_ipv4, 32'd1);
      if (ip_protocol_i == ProtoTcp) begin
        n_tcp = sat_sum(n_tcp, 32'd1);
        if (source_port_i == port_a || source_port_i == port_b ||
            dest_port_i == port_a || dest_port_i == port_b) begin
          payload = (frame_length_i > HeaderBytes) ? frame_length_i - HeaderBytes : 16'd0;
          bump_addr(WebTbl, dest_addr_i, {16'd0, payload}, drop);
        end
        if (tcp_flag_bits_i[1]) bump_addr(SynTbl, source_addr_i, 32'd1, drop);
      end else if (ip_protocol_i == ProtoUdp) begin
        n_udp = sat_sum(n_udp, 32'd1);
        if (source_port_i == port_dns || dest_port_i == port_dns) begin
          n_dns = sat_sum(n_dns, 32'd1);
        end
      end else if (ip_protocol_i == ProtoIcmp) begin
        n_icmp = sat_sum(n_icmp, 32'd1);
      end
    end
    s = '0;
    s.ipv4 = n_ipv4;
    s.tcp = n_tcp;
    s.udp = n_udp;
    s.icmp = n_icmp;
    s.dns = n_dns;
    if (fill[SynTbl] > 0) begin
      s.syn_src = addr_key[SynTbl][leader[SynTbl]];
      s.syn_cnt = addr_val[SynTbl][leader[SynTbl]];
      s.syn_vld = 1;
    end
    if (fill[WebTbl] > 0) begin
      s.web_dst = addr_key[WebTbl][leader[WebTbl]];
      s.web_bytes = addr_val[WebTbl][leader[WebTbl]];
      s.web_vld = 1;
    end
    s.dropped = drop;
    stats_q.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      port_a = WebPortAReset;
      port_b = WebPortBReset;
      port_dns = DnsPortReset;
      {n_ipv4, n_tcp, n_udp, n_icmp, n_dns} = '0;
      fill[SynTbl] = 0;
      fill[WebTbl] = 0;
      leader[SynTbl] = 0;
      leader[WebTbl] = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgWebPortA: port_a = cfg_data_i;
          CfgWebPortB: port_b = cfg_data_i;
          CfgDnsPort:  port_dns = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_packet();
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got ipv4_total %h", $time,
                   ipv4_total_i);
          errors_o++;
        end else begin
          e = stats_q.pop_front();
          check_field("ipv4_total", e.ipv4, ipv4_total_i);
          check_field("tcp_total", e.tcp, tcp_total_i);
          check_field("udp_total", e.udp, udp_total_i);
          check_field("icmp_total", e.icmp, icmp_total_i);
          check_field("dns_total", e.dns, dns_total_i);
          check_field("top_syn_source", e.syn_src, top_syn_source_i);
          check_field("top_syn_count", e.syn_cnt, top_syn_count_i);
          check_field("top_web_dest", e.web_dst, top_web_dest_i);
          check_field("top_web_bytes", e.web_bytes, top_web_bytes_i);
          check_field("syn_leader_valid", {31'd0, e.syn_vld}, {31'd0, syn_leader_valid_i});
          check_field("web_leader_valid", {31'd0, e.web_vld}, {31'd0, web_leader_valid_i});
          check_field("table_dropped", {31'd0, e.dropped}, {31'd0, table_dropped_i});
        end
      end
    end
  end

  initial errors_o = 0;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import pstt_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 3000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [15:0] ether_kind_i = 0;
  logic [7:0]  ip_protocol_i = 0;
  logic [31:0] source_addr_i = 0;
  logic [31:0] dest_addr_i = 0;
  logic [15:0] source_port_i = 0;
  logic [15:0] dest_port_i = 0;
  logic [7:0]  tcp_flag_bits_i = 0;
  logic [15:0] frame_length_i = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [31:0] ipv4_total_o, tcp_total_o, udp_total_o, icmp_total_o, dns_total_o;
  logic [31:0] top_syn_source_o, top_syn_count_o, top_web_dest_o, top_web_bytes_o;
  logic        syn_leader_valid_o, web_leader_valid_o, table_dropped_o;

  int          errors, pending;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_req;
  int          stall_cnt;
  logic [15:0] cur_a, cur_b, cur_dns;
  logic [31:0] addr_pool[16];

  always #5 clk_i = ~clk_i;

  packet_stats_top_talker u_dut (.*);

  pstt_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .ether_kind_i, .ip_protocol_i, .source_addr_i, .dest_addr_i,
    .source_port_i, .dest_port_i, .tcp_flag_bits_i, .frame_length_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .ipv4_total_i(ipv4_total_o), .tcp_total_i(tcp_total_o), .udp_total_i(udp_total_o),
    .icmp_total_i(icmp_total_o), .dns_total_i(dns_total_o),
    .top_syn_source_i(top_syn_source_o), .top_syn_count_i(top_syn_count_o),
    .top_web_dest_i(top_web_dest_o), .top_web_bytes_i(top_web_bytes_o),
    .syn_leader_valid_i(syn_leader_valid_o), .web_leader_valid_i(web_leader_valid_o),
    .table_dropped_i(table_dropped_o),
    .errors_o(errors), .pending_o(pending)
  );

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        out_ready_i <= 0;
        hold--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_packet(input logic [15:0] ek, input logic [7:0] pr,
                             input logic [31:0] sa, input logic [31:0] da,
                             input logic [15:0] sp, input logic [15:0] dp,
                             input logic [7:0] fl, input logic [15:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    ether_kind_i <= ek;
    ip_protocol_i <= pr;
    source_addr_i <= sa;
    dest_addr_i <= da;
    source_port_i <= sp;
    dest_port_i <= dp;
    tcp_flag_bits_i <= fl;
    frame_length_i <= len;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    in_valid_i <= 0;
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    case (idx)
      CfgWebPortA: cur_a = val;
      CfgWebPortB: cur_b = val;
      default:     cur_dns = val;
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(99) < 25) ? $urandom : addr_pool[$urandom_range(15)];
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(5))
      0: return cur_a;
      1: return cur_b;
      2: return cur_dns;
      3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic send_random(input bit flood);
    logic [15:0] ek, len;
    logic [7:0]  pr;
    int          r;
    ek = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : EtherIpv4;
    r = $urandom_range(9);
    pr = (r < 5) ? ProtoTcp : (r < 7) ? ProtoUdp : (r < 9) ? ProtoIcmp : 8'($urandom_range(255));
    case ($urandom_range(3))
      0: len = $urandom_range(53);
      1: len = $urandom_range(1600, 54);
      2: len = $urandom_range(65535);
      default: len = 16'hFFFF;
    endcase
    // flood: fresh addresses on web SYN segments to fill both tables
    if (flood) begin
      send_packet(EtherIpv4, ProtoTcp, $urandom, $urandom, pick_port(), cur_a,
                  8'($urandom_range(255)) | 8'h02, len);
    end else begin
      send_packet(ek, pr, pick_addr(), pick_addr(), pick_port(), pick_port(),
                  8'($urandom_range(255)), len);
    end
  endtask

  initial begin
    cur_a = WebPortAReset;
    cur_b = WebPortBReset;
    cur_dns = DnsPortReset;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    stall_cnt = 0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed packets under reset port settings
    send_packet(16'h86DD, ProtoTcp, 32'h1, 32'h2, 16'd80, 16'd80, 8'h02, 16'd100);
    send_packet(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                16'hFFFF);
    send_packet(EtherIpv4, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 16'h0);
    send_packet(EtherIpv4, 8'hFF, 32'hA, 32'hB, 16'd1, 16'd2, 8'hFF, 16'd60);
    send_packet(EtherIpv4, ProtoIcmp, 32'hC0A8_0001, 32'hC0A8_0002, 16'd0, 16'd0, 8'h00,
                16'd98);
    send_packet(EtherIpv4, ProtoUdp, 32'h0A00_0001, 32'h0A00_0002, 16'd53, 16'd5000, 8'h0,
                16'd80);
    send_packet(EtherIpv4, ProtoUdp, 32'h0A00_0001, 32'h0A00_0002, 16'd5000, 16'd53, 8'h0,
                16'd80);
    send_packet(EtherIpv4, ProtoUdp, 32'h0A00_0001, 32'h0A00_0002, 16'd52, 16'd54, 8'h0,
                16'd80);
    // web hit with zero payload, slot 0 leads on all zero
    send_packet(EtherIpv4, ProtoTcp, 32'h1111_1111, 32'h2222_2222, 16'd1234, 16'd80, 8'h10,
                16'd54);
    // short frame still inserts
    send_packet(EtherIpv4, ProtoTcp, 32'h1111_1111, 32'h3333_3333, 16'd443, 16'd999, 8'h10,
                16'd20);
    send_packet(EtherIpv4, ProtoTcp, 32'h1111_1111, 32'h3333_3333, 16'd1000, 16'd443, 8'h10,
                16'd1554);
    send_packet(EtherIpv4, ProtoTcp, 32'h1111_1111, 32'h2222_2222, 16'd80, 16'd1000, 8'h10,
                16'd1554);
    // syn ties then a new leader
    send_packet(EtherIpv4, ProtoTcp, 32'hAAAA_0001, 32'h5, 16'd3000, 16'd22, 8'h02, 16'd60);
    send_packet(EtherIpv4, ProtoTcp, 32'hAAAA_0002, 32'h5, 16'd3000, 16'd22, 8'h12, 16'd60);
    send_packet(EtherIpv4, ProtoTcp, 32'hAAAA_0002, 32'h5, 16'd3000, 16'd22, 8'hFF, 16'd60);
    // syn on a web port touches both tables
    send_packet(EtherIpv4, ProtoTcp, 32'h0, 32'hFFFF_FFFF, 16'd40000, 16'd443, 8'h02,
                16'hFFFF);
    send_packet(EtherIpv4, ProtoTcp, 32'hFFFF_FFFF, 32'h0, 16'd80, 16'd443, 8'hFD, 16'd55);
    drain();

    write_reg(CfgWebPortA, 16'h0000);
    write_reg(CfgWebPortB, 16'hFFFF);
    write_reg(CfgDnsPort, 16'h0000);
    send_idle_pct = 36;
    recv_idle_pct = 72;
    for (int i = 0; i < 400; i++) send_random(i >= 100 && i < 400);
    drain();

    write_reg(CfgWebPortA, 16'd80);
    write_reg(CfgWebPortB, 16'd443);
    write_reg(CfgDnsPort, 16'hFFFF);
    send_idle_pct = 72;
    recv_idle_pct = 36;
    for (int i = 0; i < 380; i++) send_random(1'b0);
    drain();

    write_reg(CfgWebPortA, 16'd8080);
    write_reg(CfgWebPortB, 16'($urandom_range(65535)));
    write_reg(CfgDnsPort, 16'd53);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 350; i++) send_random(1'b0);
    @(negedge clk_i);
    in_valid_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
